@@ design/gss_pkg.sv @@
package gss_pkg;

    localparam int GRAD_W     = 16;
    localparam int PROD_W     = 2 * GRAD_W;
    localparam int SUM_W      = 53;
    localparam int DSUM_W     = SUM_W + 1;
    localparam int C100_W     = SUM_W + 7;
    localparam int D91_W      = DSUM_W + 7;
    localparam int D9_W       = DSUM_W + 4;
    localparam int FRAC_W     = 16;
    localparam int DVS_W      = 61;
    localparam int DVD_W      = DVS_W + FRAC_W;
    localparam int DCNT_W     = $clog2(DVD_W);
    localparam int RATIO_W    = 48;
    localparam int SCORE_W    = 32;
    localparam int OUT_CNT_W  = 21;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [DSUM_W-1:0]  EPS_Q16   = DSUM_W'(66);
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

    localparam logic [SCORE_W-1:0] SCORE_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SCORE_W-1:0] SCORE_NEG_MAX = 32'h8000_0000;

endpackage

@@ design/gss_front.sv @@
module gss_front
    import gss_pkg::*;
#(
    parameter int CW = 21,
    parameter int GW = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [GRAD_W-1:0]       orig_gradient,
    input  logic [GRAD_W-1:0]       filtered_gradient,
    input  logic                    last_pixel,
    output logic                    push,
    output logic [2*CW+4*SUM_W-1:0] snap
);

    localparam logic [GRAD_W-1:0] GMASK = GRAD_W'((33'd1 << GW) - 33'd1);

    logic [CW-1:0]    a_reg, a_next, b_reg, b_next;
    logic [SUM_W-1:0] cra_reg, cra_next, sqa_reg, sqa_next;
    logic [SUM_W-1:0] crb_reg, crb_next, sqb_reg, sqb_next;
    logic [GRAD_W-1:0] o, g;
    logic [PROD_W-1:0] pc, ps;
    logic              ge;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                  input logic [PROD_W-1:0] v);
        logic [SUM_W:0] s;
        s = {1'b0, acc} + (SUM_W+1)'(v);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    always_comb
    begin
        o  = orig_gradient & GMASK;
        g  = filtered_gradient & GMASK;
        ge = (o >= g);
        pc = PROD_W'(o) * PROD_W'(g);
        ps = PROD_W'(o) * PROD_W'(o);
        a_next   = a_reg;
        b_next   = b_reg;
        cra_next = cra_reg;
        sqa_next = sqa_reg;
        crb_next = crb_reg;
        sqb_next = sqb_reg;
        if (ge)
        begin
            a_next   = (&a_reg) ? a_reg : a_reg + CW'(1);
            cra_next = sat_add(cra_reg, pc);
            sqa_next = sat_add(sqa_reg, ps);
        end
        else
        begin
            b_next   = (&b_reg) ? b_reg : b_reg + CW'(1);
            crb_next = sat_add(crb_reg, pc);
            sqb_next = sat_add(sqb_reg, ps);
        end
    end

    assign push = accept & last_pixel;
    assign snap = {a_next, b_next, cra_next, sqa_next, crb_next, sqb_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            b_reg   <= '0;
            cra_reg <= '0;
            sqa_reg <= '0;
            crb_reg <= '0;
            sqb_reg <= '0;
        end
        else if (accept)
        begin
            if (last_pixel)
            begin
                a_reg   <= '0;
                b_reg   <= '0;
                cra_reg <= '0;
                sqa_reg <= '0;
                crb_reg <= '0;
                sqb_reg <= '0;
            end
            else
            begin
                a_reg   <= a_next;
                b_reg   <= b_next;
                cra_reg <= cra_next;
                sqa_reg <= sqa_next;
                crb_reg <= crb_next;
                sqb_reg <= sqb_next;
            end
        end
    end

endmodule

@@ design/gss_queue.sv @@
module gss_queue
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_reg, rd_reg;
    logic [1:0]       cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = entry_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

endmodule

@@ design/gss_divider.sv @@
module gss_divider
    import gss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVS_W-1:0]  rem_reg, rem_next, den_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;
    logic [DVS_W:0]    t;
    logic              ge;

    always_comb
    begin
        t  = {rem_reg, dvd_reg[DVD_W-1]};
        ge = (t >= {1'b0, den_reg});
        if (ge)
            rem_next = DVS_W'(t - {1'b0, den_reg});
        else
            rem_next = t[DVS_W-1:0];
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/gss_back.sv @@
module gss_back
    import gss_pkg::*;
#(
    parameter int CW = 21
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  logic [2*CW+4*SUM_W-1:0]  q_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SCORE_W-1:0] smoothing_score,
    output logic signed [SCORE_W-1:0] sharpening_score,
    output logic [OUT_CNT_W-1:0]     reduced_count,
    output logic [OUT_CNT_W-1:0]     raised_count,
    output logic                     saturated
);

    localparam int SCL_W = RATIO_W + CW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_PREPD = 4'd2;
    localparam logic [3:0] ST_PREPM = 4'd3;
    localparam logic [3:0] ST_RATIO = 4'd4;
    localparam logic [3:0] ST_RWAIT = 4'd5;
    localparam logic [3:0] ST_SCALE = 4'd6;
    localparam logic [3:0] ST_SDIV  = 4'd7;
    localparam logic [3:0] ST_SWAIT = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]         state_reg;
    logic [CW-1:0]      a_reg, b_reg;
    logic [CW:0]        n_reg;
    logic [SUM_W-1:0]   cra_reg, sqa_reg, crb_reg, sqb_reg;
    logic               phase_reg, neg_reg, sat_reg, sat_next;
    logic [DSUM_W-1:0]  d_reg;
    logic [C100_W-1:0]  c100_reg;
    logic [D91_W-1:0]   d91_reg;
    logic [D9_W-1:0]    d9_reg;
    logic [RATIO_W-1:0] f_reg;
    logic [SCL_W-1:0]   prod_reg;
    logic [SCORE_W-1:0] sm_reg, sh_reg, score_next;
    logic               out_valid_reg;

    logic               div_start, div_done;
    logic [DVD_W-1:0]   div_dvd, div_q;
    logic [DVS_W-1:0]   div_dvs;
    logic               neg_next;
    logic [DVS_W-1:0]   num_next, den_next;

    gss_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (!phase_reg)
        begin
            neg_next = (D91_W'(d91_reg) < D91_W'(c100_reg));
            num_next = neg_next ? DVS_W'(D91_W'(c100_reg) - d91_reg)
                                : DVS_W'(d91_reg - D91_W'(c100_reg));
            den_next = DVS_W'(D91_W'(c100_reg) + D91_W'(d9_reg));
        end
        else
        begin
            neg_next = (DSUM_W'(crb_reg) < d_reg);
            num_next = neg_next ? DVS_W'(d_reg - DSUM_W'(crb_reg))
                                : DVS_W'(DSUM_W'(crb_reg) - d_reg);
            den_next = DVS_W'(d_reg);
        end
    end

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {num_next, {FRAC_W{1'b0}}};
        div_dvs   = den_next;
        if (state_reg == ST_RATIO)
            div_start = 1'b1;
        else if (state_reg == ST_SDIV)
        begin
            div_start = 1'b1;
            div_dvd   = DVD_W'(prod_reg);
            div_dvs   = DVS_W'(n_reg);
        end
    end

    always_comb
    begin
        sat_next   = sat_reg;
        score_next = '0;
        if (neg_reg)
        begin
            if ((|div_q[DVD_W-1:32]) || (div_q[31] && (|div_q[30:0])))
            begin
                score_next = SCORE_NEG_MAX;
                sat_next   = 1'b1;
            end
            else
                score_next = SCORE_W'(33'h1_0000_0000 - {1'b0, div_q[31:0]});
        end
        else
        begin
            if (|div_q[DVD_W-1:31])
            begin
                score_next = SCORE_POS_MAX;
                sat_next   = 1'b1;
            end
            else
                score_next = div_q[SCORE_W-1:0];
        end
    end

    assign pop              = (state_reg == ST_IDLE) && q_valid;
    assign out_valid        = out_valid_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    {a_reg, b_reg, cra_reg, sqa_reg, crb_reg, sqb_reg} <= q_data;
            end
            ST_LOAD:
            begin
                n_reg  <= {1'b0, a_reg} + {1'b0, b_reg};
                sm_reg <= '0;
                sh_reg <= '0;
            end
            ST_PREPD:
                d_reg <= (phase_reg ? DSUM_W'(sqb_reg) : DSUM_W'(sqa_reg)) + EPS_Q16;
            ST_PREPM:
            begin
                c100_reg <= C100_W'(cra_reg) * C100_W'(100);
                d91_reg  <= D91_W'(d_reg) * D91_W'(91);
                d9_reg   <= D9_W'(d_reg) * D9_W'(9);
            end
            ST_RATIO:
                neg_reg <= neg_next;
            ST_RWAIT:
            begin
                if (div_done)
                    f_reg <= (|div_q[DVD_W-1:RATIO_W]) ? RATIO_MAX : div_q[RATIO_W-1:0];
            end
            ST_SCALE:
                prod_reg <= SCL_W'(f_reg) * SCL_W'(phase_reg ? b_reg : a_reg);
            ST_SWAIT:
            begin
                if (div_done)
                begin
                    if (phase_reg)
                        sh_reg <= score_next;
                    else
                        sm_reg <= score_next;
                end
            end
            ST_SDIV, ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= 1'b0;
            sat_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            smoothing_score  <= '0;
            sharpening_score <= '0;
            reduced_count    <= '0;
            raised_count     <= '0;
            saturated        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    phase_reg <= 1'b0;
                    sat_reg   <= 1'b0;
                    if ((a_reg == '0) && (b_reg == '0))
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_PREPD;
                end
                ST_PREPD: state_reg <= ST_PREPM;
                ST_PREPM: state_reg <= ST_RATIO;
                ST_RATIO: state_reg <= ST_RWAIT;
                ST_RWAIT:
                begin
                    if (div_done)
                        state_reg <= ST_SCALE;
                end
                ST_SCALE: state_reg <= ST_SDIV;
                ST_SDIV:  state_reg <= ST_SWAIT;
                ST_SWAIT:
                begin
                    if (div_done)
                    begin
                        sat_reg <= sat_next;
                        if (phase_reg)
                            state_reg <= ST_OUT;
                        else
                        begin
                            phase_reg <= 1'b1;
                            state_reg <= ST_PREPD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        smoothing_score  <= sm_reg;
                        sharpening_score <= sh_reg;
                        reduced_count    <= OUT_CNT_W'(a_reg);
                        raised_count     <= OUT_CNT_W'(b_reg);
                        saturated        <= sat_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ design/gradient_sharpness_scorer_unit.sv @@
// Gradient sharpness scorer. Takes one word per cycle while the queue is not
// full (original and filtered gradient, unsigned Q8.8) and accumulates
// per-set counts and sums; on the word marked last_pixel the frame totals are
// queued (two frames deep) and the sums cleared, so the next frame streams in
// at once. Scoring runs through one shared 77-step restoring divider, four
// divisions per frame. Scores are signed Q15.16 and saturate with the
// saturated flag set.
module gradient_sharpness_scorer_unit
    import gss_pkg::*;
#(
    parameter int FRAME_PIXELS_LOG2 = 20,
    parameter int GRADIENT_BITS     = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [GRAD_W-1:0]         orig_gradient,
    input  logic [GRAD_W-1:0]         filtered_gradient,
    input  logic                      last_pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SCORE_W-1:0] smoothing_score,
    output logic signed [SCORE_W-1:0] sharpening_score,
    output logic [OUT_CNT_W-1:0]      reduced_count,
    output logic [OUT_CNT_W-1:0]      raised_count,
    output logic                      saturated
);

    localparam int CW     = FRAME_PIXELS_LOG2 + 1;
    localparam int GW     = (GRADIENT_BITS < GRAD_W) ? GRADIENT_BITS : GRAD_W;
    localparam int SNAP_W = 2 * CW + 4 * SUM_W;

    logic              accept, push, pop, q_full, q_valid;
    logic [SNAP_W-1:0] snap, q_data;

    assign in_ready = ~q_full;
    assign accept   = in_valid & in_ready;

    gss_front #(.CW(CW), .GW(GW)) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .orig_gradient     (orig_gradient),
        .filtered_gradient (filtered_gradient),
        .last_pixel        (last_pixel),
        .push              (push),
        .snap              (snap)
    );

    gss_queue #(.WIDTH(SNAP_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (snap),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_data)
    );

    gss_back #(.CW(CW)) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .smoothing_score  (smoothing_score),
        .sharpening_score (sharpening_score),
        .reduced_count    (reduced_count),
        .raised_count     (raised_count),
        .saturated        (saturated)
    );

endmodule

@@ bench/gradient_sharpness_scorer_unit_tb.sv @@
`timescale 1ns / 1ps

module gradient_sharpness_scorer_unit_tb;
    import gss_pkg::*;

    typedef struct {
        logic signed [SCORE_W-1:0] smoothing;
        logic signed [SCORE_W-1:0] sharpening;
        logic [OUT_CNT_W-1:0]      reduced;
        logic [OUT_CNT_W-1:0]      raised;
        logic                      sat;
    } score_t;

    class score_board;
        bit [63:0] n_reduced, n_raised;
        bit [63:0] red_cross, red_square, rai_cross, rai_square;
        score_t    scores_due[$];
        int        errors;

        function void clear_frame();
            n_reduced  = 0;
            n_raised   = 0;
            red_cross  = 0;
            red_square = 0;
            rai_cross  = 0;
            rai_square = 0;
        endfunction

        function bit [63:0] add_clip(bit [63:0] acc, bit [63:0] v, bit [63:0] lim);
            bit [63:0] s;
            s = acc + v;
            return (s > lim || s < acc) ? lim : s;
        endfunction

        // floor(num * 2^16 / den), clamped to 48 bits
        function bit [63:0] ratio_q16(bit [63:0] num, bit [63:0] den);
            bit [63:0] q, r;
            q = num / den;
            r = num % den;
            if (q > 64'hFFFF_FFFF)
                return 64'(RATIO_MAX);
            for (int i = 0; i < FRAC_W; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= den)
                begin
                    r = r - den;
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function bit [31:0] scale_score(bit neg, bit [63:0] f, bit [63:0] cnt,
                                        bit [63:0] n, ref bit sat);
            bit [63:0] mag;
            mag = (f / n) * cnt + ((f % n) * cnt) / n;
            if (neg)
            begin
                if (mag > 64'h8000_0000)
                begin
                    mag = 64'h8000_0000;
                    sat = 1'b1;
                end
                return 32'(64'h1_0000_0000 - mag);
            end
            if (mag > 64'h7FFF_FFFF)
            begin
                mag = 64'h7FFF_FFFF;
                sat = 1'b1;
            end
            return mag[31:0];
        endfunction

        function void note_word(bit [15:0] o, bit [15:0] g, bit last);
            bit [63:0] cnt_max, n, d, num, den, f, oo, og;
            bit        neg, sat;
            score_t    s;
            cnt_max = (64'd1 << (20 + 1)) - 1;
            oo = 64'(o) * 64'(o);
            og = 64'(o) * 64'(g);
            if (o >= g)
            begin
                n_reduced  = add_clip(n_reduced, 1, cnt_max);
                red_cross  = add_clip(red_cross, og, 64'(SUM_MAX));
                red_square = add_clip(red_square, oo, 64'(SUM_MAX));
            end
            else
            begin
                n_raised   = add_clip(n_raised, 1, cnt_max);
                rai_cross  = add_clip(rai_cross, og, 64'(SUM_MAX));
                rai_square = add_clip(rai_square, oo, 64'(SUM_MAX));
            end
            if (!last)
                return;
            sat = 1'b0;
            s.smoothing  = '0;
            s.sharpening = '0;
            n = n_reduced + n_raised;
            if (n != 0)
            begin
                d   = red_square + 64'(EPS_Q16);
                den = 100 * red_cross + 9 * d;
                neg = (91 * d) < (100 * red_cross);
                num = neg ? 100 * red_cross - 91 * d : 91 * d - 100 * red_cross;
                f   = ratio_q16(num, den);
                s.smoothing = scale_score(neg, f, n_reduced, n, sat);
                d   = rai_square + 64'(EPS_Q16);
                neg = rai_cross < d;
                num = neg ? d - rai_cross : rai_cross - d;
                f   = ratio_q16(num, d);
                s.sharpening = scale_score(neg, f, n_raised, n, sat);
            end
            s.reduced = n_reduced[OUT_CNT_W-1:0];
            s.raised  = n_raised[OUT_CNT_W-1:0];
            s.sat     = sat;
            scores_due.insert(scores_due.size(), s);
            clear_frame();
        endfunction

        function void check_score(score_t got);
            score_t want;
            if (scores_due.size() == 0)
            begin
                $display("%0t: unexpected result, smoothing %h", $time, got.smoothing);
                errors++;
                return;
            end
            want = scores_due.pop_front();
            if (got.smoothing !== want.smoothing)
            begin
                $display("%0t: smoothing_score expected %h actual %h",
                         $time, want.smoothing, got.smoothing);
                errors++;
            end
            if (got.sharpening !== want.sharpening)
            begin
                $display("%0t: sharpening_score expected %h actual %h",
                         $time, want.sharpening, got.sharpening);
                errors++;
            end
            if (got.reduced !== want.reduced)
            begin
                $display("%0t: reduced_count expected %0d actual %0d",
                         $time, want.reduced, got.reduced);
                errors++;
            end
            if (got.raised !== want.raised)
            begin
                $display("%0t: raised_count expected %0d actual %0d",
                         $time, want.raised, got.raised);
                errors++;
            end
            if (got.sat !== want.sat)
            begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [GRAD_W-1:0]         orig_gradient;
    logic [GRAD_W-1:0]         filtered_gradient;
    logic                      last_pixel;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [SCORE_W-1:0] smoothing_score;
    logic signed [SCORE_W-1:0] sharpening_score;
    logic [OUT_CNT_W-1:0]      reduced_count;
    logic [OUT_CNT_W-1:0]      raised_count;
    logic                      saturated;

    score_board sb;
    int         words_sent;
    int         idle_cycles;
    int         stall_left;
    bit         stall_off;
    int         frame_len;

    gradient_sharpness_scorer_unit i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .orig_gradient     (orig_gradient),
        .filtered_gradient (filtered_gradient),
        .last_pixel        (last_pixel),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .smoothing_score   (smoothing_score),
        .sharpening_score  (sharpening_score),
        .reduced_count     (reduced_count),
        .raised_count      (raised_count),
        .saturated         (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // caller is just past a rising edge
    task send_word(input logic [15:0] o, input logic [15:0] g, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        orig_gradient     <= o;
        filtered_gradient <= g;
        last_pixel        <= last;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task send_frame(input int len);
        logic [15:0] o, g;
        int          kind;
        for (int i = 0; i < len; i++)
        begin
            o    = $urandom;
            g    = $urandom;
            kind = $urandom_range(0, 9);
            if (kind == 0)
                g = o;
            else if (kind == 1)
                o = $urandom_range(0, 15);
            else if (kind == 2)
                g = $urandom_range(0, 15);
            send_word(o, g, i == len - 1);
        end
    endtask

    always @(posedge clk)
    begin
        score_t got;
        if (in_valid && in_ready)
            sb.note_word(orig_gradient, filtered_gradient, last_pixel);
        if (out_valid && out_ready)
        begin
            got.smoothing  = smoothing_score;
            got.sharpening = sharpening_score;
            got.reduced    = reduced_count;
            got.raised     = raised_count;
            got.sat        = saturated;
            sb.check_score(got);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!stall_off && $urandom_range(0, 3) == 0)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= 5000)
        begin
            $display("FAIL gradient_sharpness_scorer_unit");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.clear_frame();
        sb.errors         = 0;
        words_sent        = 0;
        idle_cycles       = 0;
        stall_left        = 0;
        stall_off         = 1'b0;
        frame_len         = 0;
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        out_ready         = 1'b0;
        orig_gradient     = '0;
        filtered_gradient = '0;
        last_pixel        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-word frames at the corners
        send_word(16'h0000, 16'h0000, 1'b1);
        send_word(16'hFFFF, 16'hFFFF, 1'b1);
        send_word(16'hFFFF, 16'h0000, 1'b1);
        send_word(16'h0000, 16'hFFFF, 1'b1);
        send_word(16'h0001, 16'hFFFF, 1'b1);
        send_word(16'h0008, 16'hFFFF, 1'b1);
        send_word(16'hFFFE, 16'hFFFF, 1'b1);
        send_word(16'h0100, 16'h0100, 1'b1);
        send_word(16'h0100, 16'h00FF, 1'b1);
        // mixed frames: all reduced, all raised, both
        send_word(16'h1234, 16'h0012, 1'b0);
        send_word(16'hFFFF, 16'h8000, 1'b0);
        send_word(16'h0040, 16'h0000, 1'b1);
        send_word(16'h0003, 16'h7777, 1'b0);
        send_word(16'h0800, 16'hFFFF, 1'b1);
        send_word(16'h0000, 16'h0001, 1'b0);
        send_word(16'h5555, 16'hAAAA, 1'b0);
        send_word(16'hAAAA, 16'h5555, 1'b0);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(16'h0002, 16'h0001, 1'b1);

        // hold the stream until the pipeline drains
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.scores_due.size() != 0) @(posedge clk);

        while (words_sent < 1150)
        begin
            if ($urandom_range(0, 19) == 0)
                stall_off = ~stall_off;
            if ($urandom_range(0, 19) == 0)
                frame_len = $urandom_range(100, 300);
            else
                frame_len = $urandom_range(1, 20);
            if (frame_len > 1150 - words_sent)
                frame_len = 1150 - words_sent;
            send_frame(frame_len);
        end
        in_valid <= 1'b0;
        stall_off = 1'b0;

        while (sb.scores_due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0 && sb.scores_due.size() == 0)
            $display("PASS gradient_sharpness_scorer_unit");
        else
            $display("FAIL gradient_sharpness_scorer_unit");
        $finish;
    end

endmodule
